@@ rtl/bsm_pkg.sv @@
package bsm_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PRG   = 3'd2,
    CMD_CHR   = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_PRG_ROM  = 3'd0,
    KIND_WRAM     = 3'd1,
    KIND_CHR_ROM  = 3'd2,
    KIND_CHR_RAM  = 3'd3,
    KIND_UNMAPPED = 3'd4
  } kind_t;

  localparam logic [1:0] CFG_PRG_MASK = 2'd0;
  localparam logic [1:0] CFG_CHR_MASK = 2'd1;
  localparam logic [1:0] CFG_CHR_RAM  = 2'd2;

  localparam int CHR_SLOTS = 8;

  typedef struct packed {
    logic [2:0] prg_layout;
    logic [1:0] chr_layout;
    logic       rom_at_6000;
    logic       chr_slot_mirror;
    logic       chr_block_on;
    logic [2:0] chr_outer_block;
  } map_mode_t;

  typedef struct packed {
    logic [10:0] page;
    logic [2:0]  kind;
  } xlat_t;

  function automatic logic [6:0] reverse7(input logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) r[6-i] = v[i];
    return r;
  endfunction

endpackage

@@ rtl/bsm_prg_xlat.sv @@
module bsm_prg_xlat (
  input  logic [15:0]        addr,
  input  logic [6:0]         bank0,
  input  logic [6:0]         bank1,
  input  logic [6:0]         bank2,
  input  logic [6:0]         bank3,
  input  bsm_pkg::map_mode_t mode,
  input  logic [8:0]         page_mask,
  output bsm_pkg::xlat_t     res
);
  import bsm_pkg::*;

  logic [6:0] r0, r1, r2, r3, last;
  logic [1:0] m, w;
  logic [8:0] p;

  always_comb begin
    m  = mode.prg_layout[1:0];
    r0 = (m == 2'd3) ? reverse7(bank0) : bank0;
    r1 = (m == 2'd3) ? reverse7(bank1) : bank1;
    r2 = (m == 2'd3) ? reverse7(bank2) : bank2;
    r3 = (m == 2'd3) ? reverse7(bank3) : bank3;
    w  = addr[14:13];
    p  = '0;
    last = r3;
    res.page = '0;
    res.kind = KIND_PRG_ROM;
    if (addr < 16'h6000) begin
      res.kind = KIND_UNMAPPED;
    end else if (addr < 16'h8000) begin
      if (!mode.rom_at_6000) begin
        res.kind = KIND_WRAM;
      end else begin
        case (m)
          2'd0: p = {r3, 2'b11};
          2'd1: p = {1'b0, r3, 1'b1};
          default: p = {2'b00, r3};
        endcase
        res.page = {2'b00, p & page_mask};
      end
    end else begin
      case (m)
        2'd0: begin
          last = mode.prg_layout[2] ? r3 : 7'h0F;
          p = {last, w};
        end
        2'd1: begin
          last = mode.prg_layout[2] ? r3 : 7'h1F;
          p = w[1] ? {1'b0, last, w[0]} : {1'b0, r1, w[0]};
        end
        default: begin
          last = mode.prg_layout[2] ? r3 : 7'h3F;
          case (w)
            2'd0: p = {2'b00, r0};
            2'd1: p = {2'b00, r1};
            2'd2: p = {2'b00, r2};
            default: p = {2'b00, last};
          endcase
        end
      endcase
      res.page = {2'b00, p & page_mask};
    end
  end

endmodule

@@ rtl/bsm_chr_xlat.sv @@
module bsm_chr_xlat (
  input  logic [12:0]                     addr,
  input  logic [bsm_pkg::CHR_SLOTS*8-1:0] chr_low,
  input  logic [bsm_pkg::CHR_SLOTS*8-1:0] chr_high,
  input  bsm_pkg::map_mode_t              mode,
  input  logic [10:0]                     page_mask,
  input  logic                            is_ram,
  output bsm_pkg::xlat_t                  res
);
  import bsm_pkg::*;

  logic [2:0]  slot, idx;
  logic [15:0] reg_v;
  logic [15:0] p;
  logic [7:0]  lo;

  always_comb begin
    slot = addr[12:10];
    case (mode.chr_layout)
      2'd0: idx = 3'd0;
      2'd1: idx = {slot[2], 2'b00};
      2'd2: idx = {slot[2:1], 1'b0};
      default: idx = slot;
    endcase
    if (mode.chr_layout[1] && mode.chr_slot_mirror && idx[2:1] == 2'b01) idx[1] = 1'b0;
    lo = chr_low[idx*8 +: 8];
    if (mode.chr_block_on) begin
      case (mode.chr_layout)
        2'd0: reg_v = {8'd0, mode.chr_outer_block, lo[4:0]};
        2'd1: reg_v = {7'd0, mode.chr_outer_block, lo[5:0]};
        2'd2: reg_v = {6'd0, mode.chr_outer_block, lo[6:0]};
        default: reg_v = {5'd0, mode.chr_outer_block, lo};
      endcase
    end else begin
      reg_v = {chr_high[idx*8 +: 8], lo};
    end
    case (mode.chr_layout)
      2'd0: p = {reg_v[12:0], slot};
      2'd1: p = {reg_v[13:0], slot[1:0]};
      2'd2: p = {reg_v[14:0], slot[0]};
      default: p = reg_v;
    endcase
    if (is_ram) begin
      res.page = {8'd0, slot};
      res.kind = KIND_CHR_RAM;
    end else begin
      res.page = p[10:0] & page_mask;
      res.kind = KIND_CHR_ROM;
    end
  end

endmodule

@@ rtl/bsm_irq_step.sv @@
module bsm_irq_step (
  input  logic [7:0] ticks,
  input  logic [1:0] direction,
  input  logic       small_prescale,
  input  logic [7:0] prescaler,
  input  logic [7:0] count,
  output logic       active,
  output logic [7:0] prescaler_nxt,
  output logic [7:0] count_nxt,
  output logic       wrap
);
  logic [8:0] clocks;
  logic [8:0] sum;
  logic [9:0] cw;
  logic [7:0] pre;

  always_comb begin
    active = (ticks != 8'd0) && (direction == 2'd1 || direction == 2'd2);
    pre = small_prescale ? {5'd0, prescaler[2:0]} : prescaler;
    if (direction == 2'd2) sum = {1'b0, ticks} + {1'b0, ~pre & (small_prescale ? 8'h07 : 8'hFF)};
    else sum = {1'b0, ticks} + {1'b0, pre};
    clocks = small_prescale ? {3'd0, sum[8:3]} : {8'd0, sum[8]};
    if (direction == 2'd2) begin
      cw = {1'b0, clocks} + {2'b00, ~count};
      count_nxt = count - clocks[7:0];
      if (small_prescale) prescaler_nxt = {prescaler[7:3], pre[2:0] - ticks[2:0]};
      else prescaler_nxt = pre - ticks;
    end else begin
      cw = {1'b0, clocks} + {2'b00, count};
      count_nxt = count + clocks[7:0];
      if (small_prescale) prescaler_nxt = {prescaler[7:3], pre[2:0] + ticks[2:0]};
      else prescaler_nxt = pre + ticks;
    end
    wrap = (clocks != 9'd0) && (cw[9:8] != 2'b00);
  end

endmodule

@@ rtl/bank_switch_mapper_with_irq_counter_unit.sv @@
// Mapper core: one command beat per cycle, registered in, registered out.
// Path from input beat to result beat: input reg, then result reg.
// Throughput: one beat per cycle; the input stalls only while the result
// register holds a beat that the receiver is stalling.
// Reset (rst_n low, synchronous): all mapper state and config to power-up
// values, pipeline empty.
module bank_switch_mapper_with_irq_counter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  input  logic [1:0]  in_event_source,
  input  logic [7:0]  in_event_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [10:0] out_page,
  output logic [2:0]  out_page_kind,
  output logic [1:0]  out_mirroring,
  output logic        out_irq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import bsm_pkg::*;

  logic        v_r;
  logic [2:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r, cnt_r;
  logic [1:0]  src_r;

  logic [8:0]  prg_mask_r;
  logic [10:0] chr_mask_r;
  logic        chr_ram_r;

  logic [6:0]  prg_bank_r [4];
  logic [CHR_SLOTS*8-1:0] chr_low_r, chr_high_r;
  map_mode_t   mode_r;
  logic [1:0]  mirror_r;
  logic        irq_en_r, irq_pend_r, small_pre_r;
  logic [1:0]  irq_src_r, irq_dir_r;
  logic [7:0]  pre_r, count_r, xor_r, mul_a_r, mul_b_r, scratch_r;

  logic        ov_r;
  logic [7:0]  rd_r;
  logic [10:0] page_r;
  logic [2:0]  kind_r;

  logic        adv;
  xlat_t       prg_res, chr_res;
  logic        t_act, t_wrap;
  logic [7:0]  t_pre, t_cnt;
  logic [15:0] prod;
  logic [7:0]  rd_nxt;
  logic [10:0] page_nxt;
  logic [2:0]  kind_nxt;
  logic        do_tick;

  assign adv       = !ov_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_read_data = rd_r;
  assign out_page      = page_r;
  assign out_page_kind = kind_r;
  assign out_mirroring = mirror_r;
  assign out_irq       = irq_pend_r;

  bsm_prg_xlat u_prg (
    .addr(addr_r), .bank0(prg_bank_r[0]), .bank1(prg_bank_r[1]),
    .bank2(prg_bank_r[2]), .bank3(prg_bank_r[3]), .mode(mode_r),
    .page_mask(prg_mask_r), .res(prg_res)
  );

  bsm_chr_xlat u_chr (
    .addr(addr_r[12:0]), .chr_low(chr_low_r), .chr_high(chr_high_r),
    .mode(mode_r), .page_mask(chr_mask_r), .is_ram(chr_ram_r), .res(chr_res)
  );

  bsm_irq_step u_irq (
    .ticks(cnt_r), .direction(irq_dir_r), .small_prescale(small_pre_r),
    .prescaler(pre_r), .count(count_r), .active(t_act),
    .prescaler_nxt(t_pre), .count_nxt(t_cnt), .wrap(t_wrap)
  );

  assign prod    = {8'd0, mul_a_r} * {8'd0, mul_b_r};
  assign do_tick = v_r && adv && cmd_r == CMD_TICK && src_r == irq_src_r && t_act;

  always_comb begin
    rd_nxt = '0;
    page_nxt = '0;
    kind_nxt = KIND_UNMAPPED;
    case (cmd_r)
      CMD_READ: begin
        case ({addr_r[15:11], addr_r[1:0]})
          7'b0101_0_00: rd_nxt = 8'd0;
          7'b0101_1_00: rd_nxt = prod[7:0];
          7'b0101_1_01: rd_nxt = prod[15:8];
          7'b0101_1_11: rd_nxt = scratch_r;
          default: rd_nxt = addr_r[15:8];
        endcase
      end
      CMD_PRG: begin
        page_nxt = prg_res.page;
        kind_nxt = prg_res.kind;
      end
      CMD_CHR: begin
        page_nxt = chr_res.page;
        kind_nxt = chr_res.kind;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      ov_r <= 1'b0;
      prg_mask_r <= 9'h1FF;
      chr_mask_r <= 11'h7FF;
      chr_ram_r <= 1'b0;
      for (int i = 0; i < 4; i++) prg_bank_r[i] <= '0;
      chr_low_r <= '0;
      chr_high_r <= '0;
      mode_r <= '0;
      mirror_r <= '0;
      irq_en_r <= 1'b0;
      irq_pend_r <= 1'b0;
      small_pre_r <= 1'b0;
      irq_src_r <= '0;
      irq_dir_r <= '0;
      pre_r <= '0;
      count_r <= '0;
      xor_r <= '0;
      mul_a_r <= '0;
      mul_b_r <= '0;
      scratch_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PRG_MASK: prg_mask_r <= cfg_data[8:0];
          CFG_CHR_MASK: chr_mask_r <= cfg_data;
          CFG_CHR_RAM:  chr_ram_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (adv) begin
        v_r <= in_valid;
        ov_r <= v_r;
      end
      if (do_tick) begin
        pre_r <= t_pre;
        count_r <= t_cnt;
        if (t_wrap && irq_en_r) irq_pend_r <= 1'b1;
      end
      if (v_r && adv && cmd_r == CMD_WRITE) begin
        if (addr_r[15:11] == 5'b01011) begin
          case (addr_r[1:0])
            2'd0: mul_a_r <= data_r;
            2'd1: mul_b_r <= data_r;
            2'd3: scratch_r <= data_r;
            default: ;
          endcase
        end
        // bank registers decode A11-A3 as zero; IRQ and mode registers ignore them
        case (addr_r[15:12])
          4'h8: if (addr_r[11:3] == 9'd0) prg_bank_r[addr_r[1:0]] <= data_r[6:0];
          4'h9: if (addr_r[11:3] == 9'd0) chr_low_r[addr_r[2:0]*8 +: 8] <= data_r;
          4'hA: if (addr_r[11:3] == 9'd0) chr_high_r[addr_r[2:0]*8 +: 8] <= data_r;
          4'hC: begin
            case (addr_r[2:0])
              3'd0: begin
                irq_en_r <= data_r[0];
                if (!data_r[0]) irq_pend_r <= 1'b0;
              end
              3'd1: begin
                irq_dir_r <= data_r[7:6];
                small_pre_r <= data_r[2];
                irq_src_r <= data_r[1:0];
              end
              3'd2: begin
                irq_en_r <= 1'b0;
                irq_pend_r <= 1'b0;
              end
              3'd3: irq_en_r <= 1'b1;
              3'd4: pre_r <= data_r ^ xor_r;
              3'd5: count_r <= data_r ^ xor_r;
              3'd6: xor_r <= data_r;
              default: ;
            endcase
          end
          4'hD: begin
            case (addr_r[2:0])
              3'd0: begin
                mode_r.prg_layout <= data_r[2:0];
                mode_r.chr_layout <= data_r[4:3];
                mode_r.rom_at_6000 <= data_r[7];
              end
              3'd1: mirror_r <= data_r[1:0];
              3'd3: begin
                mode_r.chr_slot_mirror <= data_r[7];
                mode_r.chr_block_on <= !data_r[5];
                mode_r.chr_outer_block <= {data_r[4:3], data_r[0]};
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r  <= in_cmd;
      addr_r <= in_addr;
      data_r <= in_data;
      src_r  <= in_event_source;
      cnt_r  <= in_event_count;
      rd_r   <= rd_nxt;
      page_r <= page_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule

@@ bench/tb_bank_switch_mapper_with_irq_counter_unit.sv @@
`timescale 1ns / 100ps

module tb_bank_switch_mapper_with_irq_counter_unit;
  import bsm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [1:0]  in_event_source;
  logic [7:0]  in_event_count;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic [10:0] out_page;
  logic [2:0]  out_page_kind;
  logic [1:0]  out_mirroring;
  logic        out_irq;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  bank_switch_mapper_with_irq_counter_unit u_top (.*);

  typedef struct packed {
    logic [7:0]  read_data;
    logic [10:0] page;
    logic [2:0]  kind;
    logic [1:0]  mirroring;
    logic        irq;
  } beat_t;

  beat_t expected_q[$];
  int    error_count;
  int    beats_sent;
  int    beats_checked;
  int    idle_cycles;
  bit    stall_on;
  int    stall_style;

  // mapper mirror
  logic [8:0]  m_prg_mask;
  logic [10:0] m_chr_mask;
  logic        m_chr_ram;
  logic [6:0]  m_prg_bank[4];
  logic [7:0]  m_chr_low[8];
  logic [7:0]  m_chr_high[8];
  logic [2:0]  m_prg_layout;
  logic [1:0]  m_chr_layout;
  logic        m_rom6000, m_slot_mirror, m_block_on;
  logic [1:0]  m_mirror;
  logic [2:0]  m_outer;
  logic        m_irq_en, m_irq_pend, m_small;
  logic [1:0]  m_src_sel, m_dir;
  logic [7:0]  m_pre, m_cnt, m_key, m_mul_a, m_mul_b, m_scratch;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [6:0] flip7(input logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) r[6-i] = v[i];
    return r;
  endfunction

  function automatic int bank_of(input int i);
    return (m_prg_layout[1:0] == 2'd3) ? flip7(m_prg_bank[i]) : m_prg_bank[i];
  endfunction

  function automatic int chr_bank_of(input int idx);
    int sh;
    if (m_chr_layout >= 2 && m_slot_mirror && (idx == 2 || idx == 3)) idx -= 2;
    sh = 5 + m_chr_layout;
    if (m_block_on)
      return (m_chr_low[idx] & ((1 << sh) - 1)) | (m_outer << sh);
    return {m_chr_high[idx], m_chr_low[idx]};
  endfunction

  task automatic mapper_reset_state();
    m_prg_mask = 9'h1FF; m_chr_mask = 11'h7FF; m_chr_ram = 0;
    for (int i = 0; i < 8; i++) begin
      m_chr_low[i] = 0; m_chr_high[i] = 0;
      if (i < 4) m_prg_bank[i] = 0;
    end
    m_prg_layout = 0; m_chr_layout = 0; m_rom6000 = 0; m_slot_mirror = 0;
    m_block_on = 0; m_mirror = 0; m_outer = 0; m_irq_en = 0; m_irq_pend = 0;
    m_small = 0; m_src_sel = 0; m_dir = 0; m_pre = 0; m_cnt = 0; m_key = 0;
    m_mul_a = 0; m_mul_b = 0; m_scratch = 0;
  endtask

  task automatic advance_counter(input int ticks);
    int msk, period, pre, cnt, clocks, wraps;
    if (ticks == 0 || (m_dir != 2'd1 && m_dir != 2'd2)) return;
    msk = m_small ? 7 : 255;
    period = msk + 1;
    pre = m_pre & msk;
    cnt = m_cnt;
    wraps = 0;
    if (m_dir == 2'd2) begin
      clocks = (ticks + msk - pre) / period;
      pre = (pre - ticks) & msk;
      if (clocks != 0) begin
        wraps = (clocks + 255 - cnt) >> 8;
        cnt = (cnt - clocks) & 255;
      end
    end else begin
      clocks = (ticks + pre) / period;
      pre = (pre + ticks) & msk;
      if (clocks != 0) begin
        wraps = (clocks + cnt) >> 8;
        cnt = (cnt + clocks) & 255;
      end
    end
    m_pre = (m_pre & ~msk[7:0]) | pre[7:0];
    m_cnt = cnt[7:0];
    if (wraps != 0 && m_irq_en) m_irq_pend = 1;
  endtask

  task automatic apply_write(input logic [15:0] a, input logic [7:0] d);
    case (a & 16'hF803)
      16'h5800: m_mul_a = d;
      16'h5801: m_mul_b = d;
      16'h5803: m_scratch = d;
      default: ;
    endcase
    case (a & 16'hF000)
      16'h8000: begin
        if ((a & 16'h0FF8) == 0) m_prg_bank[a[1:0]] = d[6:0];
        return;
      end
      16'h9000: begin
        if ((a & 16'h0FF8) == 0) m_chr_low[a[2:0]] = d;
        return;
      end
      16'hA000: begin
        if ((a & 16'h0FF8) == 0) m_chr_high[a[2:0]] = d;
        return;
      end
      default: ;
    endcase
    case (a & 16'hF007)
      16'hC000: begin
        m_irq_en = d[0];
        if (!d[0]) m_irq_pend = 0;
      end
      16'hC001: begin
        m_dir = d[7:6]; m_small = d[2]; m_src_sel = d[1:0];
      end
      16'hC002: begin
        m_irq_en = 0; m_irq_pend = 0;
      end
      16'hC003: m_irq_en = 1;
      16'hC004: m_pre = d ^ m_key;
      16'hC005: m_cnt = d ^ m_key;
      16'hC006: m_key = d;
      16'hD000: begin
        m_prg_layout = d[2:0]; m_chr_layout = d[4:3]; m_rom6000 = d[7];
      end
      16'hD001: m_mirror = d[1:0];
      16'hD003: begin
        m_slot_mirror = d[7]; m_block_on = !d[5]; m_outer = {d[4:3], d[0]};
      end
      default: ;
    endcase
  endtask

  task automatic predict_mapper(input logic [2:0] cmd, input logic [15:0] a,
                                input logic [7:0] d, input logic [1:0] src,
                                input logic [7:0] n, output beat_t r);
    int p, w, last, slot, prod;
    r = '0;
    r.kind = KIND_UNMAPPED;
    case (cmd)
      CMD_WRITE: apply_write(a, d);
      CMD_READ: begin
        prod = m_mul_a * m_mul_b;
        case (a & 16'hF803)
          16'h5000: r.read_data = 8'd0;
          16'h5800: r.read_data = prod[7:0];
          16'h5801: r.read_data = prod[15:8];
          16'h5803: r.read_data = m_scratch;
          default:  r.read_data = a[15:8];
        endcase
      end
      CMD_PRG: begin
        if (a < 16'h6000) r.kind = KIND_UNMAPPED;
        else if (a < 16'h8000 && !m_rom6000) r.kind = KIND_WRAM;
        else begin
          if (a < 16'h8000) begin
            case (m_prg_layout[1:0])
              2'd0: p = (bank_of(3) << 2) + 3;
              2'd1: p = (bank_of(3) << 1) + 1;
              default: p = bank_of(3);
            endcase
          end else begin
            w = a[14:13];
            case (m_prg_layout[1:0])
              2'd0: begin
                last = m_prg_layout[2] ? bank_of(3) : 'h0F;
                p = (last << 2) + w;
              end
              2'd1: begin
                last = m_prg_layout[2] ? bank_of(3) : 'h1F;
                p = (w < 2) ? (bank_of(1) << 1) + w : (last << 1) + (w - 2);
              end
              default: begin
                last = m_prg_layout[2] ? bank_of(3) : 'h3F;
                p = (w < 3) ? bank_of(w) : last;
              end
            endcase
          end
          r.page = 11'(p & m_prg_mask);
          r.kind = KIND_PRG_ROM;
        end
      end
      CMD_CHR: begin
        slot = a[12:10];
        if (m_chr_ram) begin
          r.page = 11'(slot);
          r.kind = KIND_CHR_RAM;
        end else begin
          case (m_chr_layout)
            2'd0: p = (chr_bank_of(0) << 3) + slot;
            2'd1: p = (slot < 4) ? (chr_bank_of(0) << 2) + slot
                                 : (chr_bank_of(4) << 2) + (slot - 4);
            2'd2: p = (chr_bank_of(slot & 6) << 1) + (slot & 1);
            default: p = chr_bank_of(slot);
          endcase
          r.page = 11'(p & m_chr_mask);
          r.kind = KIND_CHR_ROM;
        end
      end
      CMD_TICK: if (src == m_src_sel) advance_counter(n);
      default: ;
    endcase
    r.mirroring = m_mirror;
    r.irq = m_irq_pend;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch %s at beat %0d: got %0h expected %0h", what, beats_checked, got,
             want);
  endtask

  // sender
  int burst_left;

  task automatic send_beat(input logic [2:0] cmd, input logic [15:0] a,
                           input logic [7:0] d, input logic [1:0] src,
                           input logic [7:0] n);
    beat_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid = 1; in_cmd = cmd; in_addr = a; in_data = d;
    in_event_source = src; in_event_count = n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_mapper(cmd, a, d, src, n, r);
    expected_q.push_back(r);
    beats_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_cpu(input logic [15:0] a, input logic [7:0] d);
    send_beat(CMD_WRITE, a, d, 0, 0);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [10:0] val);
    drain();
    cfg_valid = 1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PRG_MASK: m_prg_mask = val[8:0];
      CFG_CHR_MASK: m_chr_mask = val;
      CFG_CHR_RAM:  m_chr_ram = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // checker and receiver stall
  always @(posedge clk) begin
    beat_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        idle_cycles <= 0;
        if (expected_q.size() == 0) report_mismatch("unexpected beat", 0, 0);
        else begin
          e = expected_q.pop_front();
          if (out_read_data !== e.read_data) report_mismatch("read_data", out_read_data,
                                                             e.read_data);
          if (out_page !== e.page) report_mismatch("page", out_page, e.page);
          if (out_page_kind !== e.kind) report_mismatch("page_kind", out_page_kind, e.kind);
          if (out_mirroring !== e.mirroring) report_mismatch("mirroring", out_mirroring,
                                                             e.mirroring);
          if (out_irq !== e.irq) report_mismatch("irq", out_irq, e.irq);
        end
        beats_checked++;
      end else if (in_valid && !in_stall) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("watchdog expired");
        $display("tb_bank_switch_mapper_with_irq_counter_unit failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!stall_on) out_stall <= 0;
    else case (stall_style)
      0: out_stall <= ($urandom_range(0, 3) == 0);
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (($urandom_range(0, 15)) < 12);
    endcase
    if ($urandom_range(0, 63) == 0) begin
      stall_on <= $urandom_range(0, 2) != 0;
      stall_style <= $urandom_range(0, 2);
    end
  end

  task automatic test_reset_values();
    send_beat(CMD_PRG, 16'hE000, 0, 0, 0);
    send_beat(CMD_PRG, 16'h6000, 0, 0, 0);
    send_beat(CMD_PRG, 16'h5FFF, 0, 0, 0);
    send_beat(CMD_CHR, 16'hFFFF, 0, 0, 0);
    send_beat(CMD_READ, 16'h1234, 0, 0, 0);
    send_beat(3'd5, 16'hFFFF, 8'hFF, 3, 8'hFF);
    send_beat(3'd7, 0, 0, 0, 0);
  endtask

  task automatic test_directed_regs();
    write_cpu(16'h5800, 8'hFF);
    write_cpu(16'h5801, 8'hFF);
    write_cpu(16'h5803, 8'hA5);
    send_beat(CMD_READ, 16'h5800, 0, 0, 0);
    send_beat(CMD_READ, 16'h5801, 0, 0, 0);
    send_beat(CMD_READ, 16'h5803, 0, 0, 0);
    send_beat(CMD_READ, 16'h5000, 0, 0, 0);
    write_cpu(16'h8003, 8'h41);
    write_cpu(16'h8FF8, 8'h11);
    write_cpu(16'hD000, 8'h83);
    send_beat(CMD_PRG, 16'h6000, 0, 0, 0);
    send_beat(CMD_PRG, 16'hFFFF, 0, 0, 0);
    write_cpu(16'hD001, 8'h03);
    write_cpu(16'hC001, 8'h40);
    write_cpu(16'hC003, 0);
    write_cpu(16'hC005, 8'hFE);
    send_beat(CMD_TICK, 0, 0, 0, 8'hFF);
    send_beat(CMD_TICK, 0, 0, 0, 8'hFF);
    send_beat(CMD_TICK, 0, 0, 1, 8'hFF);
    write_cpu(16'hC002, 0);
    write_cpu(16'hC001, 8'h85);
    write_cpu(16'hC000, 1);
    send_beat(CMD_TICK, 0, 0, 1, 8'hFF);
  endtask

  function automatic logic [15:0] pick_write_addr();
    logic [15:0] a;
    case ($urandom_range(0, 9))
      0: a = 16'h8000 | $urandom_range(0, 3);
      1: a = 16'h9000 | $urandom_range(0, 7);
      2: a = 16'hA000 | $urandom_range(0, 7);
      3, 4: a = 16'hC000 | $urandom_range(0, 7);
      5: a = 16'hD000 | $urandom_range(0, 3);
      6: a = 16'h5800 | $urandom_range(0, 3);
      7: a = {$urandom_range(8, 15), 12'h000} | ($urandom_range(0, 1) ? 16'h0FF8 : 16'h0);
      default: a = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 3) == 0) a = a | ($urandom_range(0, 255) << 4) & 16'h07F8;
    return a;
  endfunction

  task automatic run_random(input int n);
    logic [2:0] cmd;
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          cmd = CMD_WRITE;
          a = pick_write_addr();
        end
        6, 7: begin
          cmd = CMD_READ;
          a = $urandom_range(0, 1) ? (16'h5000 | $urandom_range(0, 16'h0FFF))
                                   : $urandom_range(0, 65535);
        end
        8, 9, 10: begin
          cmd = CMD_PRG;
          a = $urandom_range(0, 65535);
        end
        11, 12, 13: begin
          cmd = CMD_CHR;
          a = $urandom_range(0, 65535);
        end
        14, 15, 16, 17, 18: begin
          cmd = CMD_TICK;
          a = $urandom_range(0, 65535);
        end
        default: begin
          cmd = $urandom_range(5, 7);
          a = $urandom_range(0, 65535);
        end
      endcase
      send_beat(cmd, a, $urandom_range(0, 255),
                (cmd == CMD_TICK && $urandom_range(0, 3) != 0) ? m_src_sel
                                                               : $urandom_range(0, 3),
                $urandom_range(0, 3) == 0 ? 8'hFF : $urandom_range(0, 40));
    end
  endtask

  task automatic test_config_sweep();
    write_cfg(CFG_CHR_RAM, 1);
    run_random(40);
    write_cfg(CFG_CHR_RAM, 0);
    write_cfg(CFG_PRG_MASK, 0);
    write_cfg(CFG_CHR_MASK, 0);
    run_random(40);
    write_cfg(CFG_PRG_MASK, 9'h01F);
    write_cfg(CFG_CHR_MASK, 11'h0FF);
    run_random(60);
    write_cfg(CFG_PRG_MASK, 9'h1FF);
    write_cfg(CFG_CHR_MASK, 11'h7FF);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_cmd = 0; in_addr = 0; in_data = 0;
    in_event_source = 0; in_event_count = 0; out_stall = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    error_count = 0; beats_sent = 0; beats_checked = 0; idle_cycles = 0;
    stall_on = 0; stall_style = 0; burst_left = 0;
    mapper_reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_reset_values();
    test_directed_regs();
    test_config_sweep();
    run_random(220);
    drain();
    run_random(240);
    drain();
    $display("covered %0d command beats, %0d results checked, through all map modes,",
             beats_sent, beats_checked);
    $display("mask and CHR RAM settings, and up/down counter ticks");
    if (error_count == 0) $display("tb_bank_switch_mapper_with_irq_counter_unit passed");
    else $display("tb_bank_switch_mapper_with_irq_counter_unit failed");
    $finish;
  end

endmodule
